// ===== sv/assert_macros.svh =====
// Assertion macros used by the top RTL file of the searchable queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== sv/sfq_pkg.sv =====
// Package with the types and constants of the searchable queue.
package sfq_pkg;

   localparam int CMD_BITS    = 2;
   localparam int DATA_BITS   = 32;
   localparam int POS_BITS    = 5;
   localparam int STATUS_BITS = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_SEARCH  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== sv/sfq_req_if.sv =====
// Command channel interface of the searchable queue.
interface sfq_req_if;
   import sfq_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CMD_BITS-1:0]         command;
   logic signed [DATA_BITS-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

// ===== sv/sfq_rsp_if.sv =====
// Result channel interface of the searchable queue.
interface sfq_rsp_if;
   import sfq_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] data_out;
   logic [POS_BITS-1:0]         position;
   logic [POS_BITS-1:0]         fill_count;
   logic [STATUS_BITS-1:0]      status;

   modport source (output valid, output data_out, output position, output fill_count,
                   output status, input ready);
   modport sink (input valid, input data_out, input position, input fill_count,
                 input status, output ready);
endinterface

// ===== sv/searchable_fifo_queue_top.sv =====
// Searchable first-in first-out queue with a sequenced one-entry-a-cycle search.
//
//   Channel    Direction  Contents
//   req_chan   in         command, value
//   rsp_chan   out        data_out, position, fill_count, status
//
// An enqueue, a refused command or an unused command passes from ST_IDLE to ST_DONE,
// a dequeue through ST_DEQ. A search reads one stored entry a cycle from the newest backwards
// in ST_SCAN through the single memory read port.
// Reset is synchronous and empties the queue; the stored values need no clearing.
// A result waits in the output register while the next command is taken; a further
// result waits in its state until that register is free.
module searchable_fifo_queue_top #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   sfq_req_if.sink     req_chan,
   sfq_rsp_if.source   rsp_chan
);
   import sfq_pkg::*;

`include "assert_macros.svh"

   localparam int PTR_W      = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int STORE_BITS = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;

   state_type                state_ff, state_in;
   logic [STORE_BITS-1:0]    mem_ff [DEPTH];
   logic [STORE_BITS-1:0]    rd_data_ff;
   logic [PTR_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [STORE_BITS-1:0]    val_ff, val_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic [COUNT_W-1:0]       scan_ff, scan_in;
   logic [PTR_W-1:0]         oldest_ff, oldest_in;
   logic [PTR_W-1:0]         next_free_ff, next_free_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [STORE_BITS-1:0]    res_data_ff, res_data_in;
   logic [COUNT_W-1:0]       res_pos_ff, res_pos_in;
   status_type               res_stat_ff, res_stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic [POS_BITS-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [POS_BITS-1:0]      rsp_fill_ff, rsp_fill_in;
   status_type               rsp_stat_ff, rsp_stat_in;
   logic [STORE_BITS+DATA_BITS-1:0] data_ext;
   logic [COUNT_W+POS_BITS-1:0]     pos_ext;
   logic [COUNT_W+POS_BITS-1:0]     fill_ext;
   logic                     full;
   logic                     empty;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign data_ext = {{DATA_BITS{1'b0}}, res_data_ff};
   assign pos_ext  = {{POS_BITS{1'b0}}, res_pos_ff};
   assign fill_ext = {{POS_BITS{1'b0}}, count_ff};

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      ptr_in       = ptr_ff;
      scan_in      = scan_ff;
      oldest_in    = oldest_ff;
      next_free_in = next_free_ff;
      count_in     = count_ff;
      res_data_in  = res_data_ff;
      res_pos_in   = res_pos_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_stat_in  = rsp_stat_ff;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      req_chan.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               val_in      = req_chan.value[STORE_BITS-1:0];
               res_data_in = '0;
               res_pos_in  = '0;
               res_stat_in = STAT_OK;
               state_in    = ST_DONE;
               case (cmd_type'(req_chan.command))
                  CMD_ENQUEUE: begin
                     if (full) begin
                        res_stat_in = STAT_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        next_free_in = ring_next(next_free_ff);
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (empty) begin
                        res_stat_in = STAT_EMPTY;
                     end else begin
                        rd_addr  = oldest_ff;
                        state_in = ST_DEQ;
                     end
                  end
                  CMD_SEARCH: begin
                     if (!empty) begin
                        rd_addr  = ring_prev(next_free_ff);
                        ptr_in   = ring_prev(next_free_ff);
                        scan_in  = count_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DEQ: begin
            res_data_in = rd_data_ff;
            oldest_in   = ring_next(oldest_ff);
            count_in    = count_ff - 1'b1;
            state_in    = ST_DONE;
         end
         ST_SCAN: begin
            if (rd_data_ff == val_ff) begin
               res_pos_in = scan_ff;
               state_in   = ST_DONE;
            end else if (scan_ff == COUNT_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               rd_addr = ring_prev(ptr_ff);
               ptr_in  = ring_prev(ptr_ff);
               scan_in = scan_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ext[DATA_BITS-1:0];
               rsp_pos_in   = pos_ext[POS_BITS-1:0];
               rsp_fill_in  = fill_ext[POS_BITS-1:0];
               rsp_stat_in  = res_stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         next_free_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         next_free_ff <= next_free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      scan_ff     <= scan_in;
      res_data_ff <= res_data_in;
      res_pos_ff  <= res_pos_in;
      res_stat_ff <= res_stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_fill_ff <= rsp_fill_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[next_free_ff] <= val_in;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.data_out   = rsp_data_ff;
   assign rsp_chan.position   = rsp_pos_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;
   assign rsp_chan.status     = rsp_stat_ff;

   `ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_W'(DEPTH))
   `ASSERT_SAME(a_ring_aligned, clock, reset, empty || full, oldest_ff == next_free_ff)
   `ASSERT_SAME(a_scan_range, clock, reset, state_ff == ST_SCAN, scan_ff != '0 && scan_ff <= count_ff)
   `ASSERT_NEXT(a_scan_holds_count, clock, reset, state_ff == ST_SCAN, $stable(count_ff))

endmodule

// ===== test/searchable_fifo_queue_checker.sv =====
// Checker that predicts and compares every result transfer of the searchable queue.
module searchable_fifo_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_data_out,
   input  logic [4:0]  rsp_position,
   input  logic [4:0]  rsp_fill_count,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending_count
);
   import sfq_pkg::*;

   localparam int QUEUE_DEPTH = 16;

   typedef struct packed {
      logic [31:0] data_out;
      logic [4:0]  position;
      logic [4:0]  fill_count;
      status_type  status;
   } queue_result_type;

   logic [31:0]      held_value [QUEUE_DEPTH];
   logic [3:0]       oldest_slot;
   logic [3:0]       free_slot;
   logic [4:0]       held_count;
   queue_result_type awaited_results [$];
   int               mismatch_total;

   assign fail_count = mismatch_total;

   initial begin
      mismatch_total = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s is %0d, expected %0d", $time, what,
               $signed(got), $signed(want));
      mismatch_total++;
   endtask

   function automatic queue_result_type apply_command(input logic [1:0] command,
                                                      input logic [31:0] value);
      queue_result_type result;
      logic [3:0]       slot;
      int               k;
      result = '{data_out: '0, position: '0, fill_count: '0, status: STAT_OK};
      case (command)
         CMD_ENQUEUE: begin
            if (held_count >= QUEUE_DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               held_value[free_slot] = value;
               free_slot  = free_slot + 4'd1;
               held_count = held_count + 5'd1;
            end
         end
         CMD_DEQUEUE: begin
            if (held_count == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               result.data_out = held_value[oldest_slot];
               oldest_slot = oldest_slot + 4'd1;
               held_count  = held_count - 5'd1;
            end
         end
         CMD_SEARCH: begin
            // The newest matching entry wins, so the scan runs from the newest backwards.
            for (k = held_count; k > 0 && result.position == 0; k--) begin
               slot = oldest_slot + 4'(k - 1);
               if (held_value[slot] == value) begin
                  result.position = 5'(k);
               end
            end
         end
         default: begin
         end
      endcase
      result.fill_count = held_count;
      return result;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         oldest_slot = '0;
         free_slot   = '0;
         held_count  = '0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result transfer, data_out", rsp_data_out, '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data_out !== want.data_out) begin
                  report_mismatch("data_out", rsp_data_out, want.data_out);
               end
               if (rsp_position !== want.position) begin
                  report_mismatch("position", 32'(rsp_position), 32'(want.position));
               end
               if (rsp_fill_count !== want.fill_count) begin
                  report_mismatch("fill_count", 32'(rsp_fill_count), 32'(want.fill_count));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_results.push_back(apply_command(req_command, req_value));
         end
      end
      pending_count <= awaited_results.size();
   end

endmodule

// ===== test/searchable_fifo_queue_top_tb.sv =====
// Testbench top of the searchable queue: clock, reset, command stimulus and verdict.
module searchable_fifo_queue_top_tb;
   import sfq_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         LONG_HOLD      = 240;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         PHASE_ITEMS    = 60;
   localparam int         PHASE_TOTAL    = 8;
   localparam int         POOL_SIZE      = 12;

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_kind_type;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          pending_count;
   int          quiet_cycles;
   int          stall_left;
   bit          no_idle;
   bit          hold_request;
   logic [31:0] value_pool [POOL_SIZE];

   sfq_req_if req_chan ();
   sfq_rsp_if rsp_chan ();

   searchable_fifo_queue_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   searchable_fifo_queue_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_command    (req_chan.command),
      .req_value      (req_chan.value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_data_out   (rsp_chan.data_out),
      .rsp_position   (rsp_chan.position),
      .rsp_fill_count (rsp_chan.fill_count),
      .rsp_status     (rsp_chan.status),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 3) != 0) begin
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_command(input phase_kind_type kind);
      int r;
      int enq_limit;
      int deq_limit;
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL: begin
            enq_limit = 68;
            deq_limit = 78;
         end
         PHASE_DRAIN: begin
            enq_limit = 15;
            deq_limit = 75;
         end
         default: begin
            enq_limit = 40;
            deq_limit = 70;
         end
      endcase
      if (r < enq_limit) begin
         return CMD_ENQUEUE;
      end else if (r < deq_limit) begin
         return CMD_DEQUEUE;
      end else if (r < 97) begin
         return CMD_SEARCH;
      end
      return CMD_UNUSED;
   endfunction

   // Called at a rising edge; returns at the edge at which the command is transferred.
   task automatic send_command(input logic [1:0] command, input logic [31:0] value);
      int gap;
      gap = no_idle ? 0 : idle_length();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= command;
      req_chan.value   <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            stall_left = LONG_HOLD - 1;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = idle_length();
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL searchable_fifo_queue_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      phase_kind_type phase_plan [PHASE_TOTAL];
      int             p;
      int             n;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.command = CMD_ENQUEUE;
      req_chan.value   = '0;
      quiet_cycles     = 0;
      no_idle          = 1'b0;
      hold_request     = 1'b0;
      phase_plan = '{PHASE_FILL, PHASE_MIX, PHASE_DRAIN, PHASE_FILL,
                     PHASE_FILL, PHASE_DRAIN, PHASE_MIX, PHASE_DRAIN};
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (n = 4; n < POOL_SIZE; n++) begin
         value_pool[n] = $urandom;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, unused code, extremes, duplicates and draining to empty.
      send_command(CMD_SEARCH, 32'd5);
      send_command(CMD_DEQUEUE, 32'h5a5a_5a5a);
      send_command(CMD_UNUSED, 32'h7fff_ffff);
      send_command(CMD_ENQUEUE, 32'h8000_0000);
      send_command(CMD_ENQUEUE, 32'h7fff_ffff);
      send_command(CMD_ENQUEUE, 32'h0000_0000);
      send_command(CMD_ENQUEUE, 32'hffff_ffff);
      send_command(CMD_ENQUEUE, 32'h7fff_ffff);
      send_command(CMD_SEARCH, 32'h7fff_ffff);
      send_command(CMD_SEARCH, 32'h8000_0000);
      send_command(CMD_SEARCH, 32'hffff_ffff);
      send_command(CMD_SEARCH, 32'h0001_2345);
      send_command(CMD_UNUSED, 32'h8000_0000);
      send_command(CMD_DEQUEUE, 32'hffff_ffff);
      send_command(CMD_SEARCH, 32'h7fff_ffff);
      for (n = 0; n < 4; n++) begin
         send_command(CMD_DEQUEUE, $urandom);
      end
      send_command(CMD_DEQUEUE, 32'h0);
      send_command(CMD_SEARCH, 32'h0);

      for (p = 0; p < PHASE_TOTAL; p++) begin
         no_idle = (p == 1 || p == 3 || p == 4 || p == 6);
         // The receiver holds off while commands keep coming, so the command channel backs up.
         if (p == 1 || p == 4) begin
            hold_request = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_command(pick_command(phase_plan[p]), pick_value());
         end
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS searchable_fifo_queue_top");
      end else begin
         $display("FAIL searchable_fifo_queue_top");
      end
      $finish;
   end

endmodule
